// ===== sv/pht_pkg.sv =====
// Shared types and constants for the path hash table.
// Holds command codes, hash constants and the stored slot layout; no dependencies.
package pht_pkg;

   localparam int BUCKETS_DEF = 4096;
   localparam int WAYS_DEF    = 4;

   localparam logic [16:0] HASH_PRIME = 17'd103669;
   localparam logic [12:0] HASH_SPAN  = 13'd5003;

   // floor(2^48 / prime) and floor(2^44 / span): the estimate is off by at most one
   localparam logic [31:0] PRIME_RCP = 32'((64'd1 << 48) / 64'd103669);
   localparam logic [31:0] SPAN_RCP  = 32'((64'd1 << 44) / 64'd5003);

   localparam int KEY_W = 56;
   localparam int TOT_W = 32;
   localparam int SYM_W = 16;
   localparam int CNT_W = 15;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_FIND  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TOT_W-1:0] total;
      logic [SYM_W-1:0] symbol;
   } slot_type;

endpackage

// ===== sv/pht_hash.sv =====
// Bucket index unit: staged multiplies with reciprocal modulo reduction.
// Depends on pht_pkg. Inputs must stay stable from start until done.
module pht_hash #(
   parameter int BUCKETS = pht_pkg::BUCKETS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [7:0]                 lang_model,
   input  logic [23:0]                in_pos,
   input  logic [15:0]                ctx_pos,
   output logic                       done,
   output logic [$clog2(BUCKETS)-1:0] bucket
);
   import pht_pkg::*;

   localparam int BW = $clog2(BUCKETS);
   localparam int NSTG = 11;
   localparam logic [22:0] BKT_RCP = 23'((64'd1 << 26) / 64'(BUCKETS));

   logic [NSTG-1:0] vld_ff;
   logic [31:0]     x_ff;
   logic [63:0]     m1_ff;
   logic [31:0]     qp_ff;
   logic [31:0]     h1_ff;
   logic [31:0]     y_ff;
   logic [63:0]     m2_ff;
   logic [31:0]     q2p_ff;
   logic [12:0]     src_ff;
   logic [35:0]     m3_ff;
   logic [31:0]     q3b_ff;
   logic [BW-1:0]   bucket_ff;

   logic [17:0] r1_in;
   logic [17:0] r1c_in;
   logic [13:0] r2_in;
   logic [12:0] r2c_in;
   logic [13:0] r3_in;
   logic [13:0] r3c_in;

   always_comb begin
      r1_in  = 18'(x_ff - qp_ff);
      r1c_in = (r1_in >= 18'(HASH_PRIME)) ? 18'(r1_in - 18'(HASH_PRIME)) : r1_in;
      r2_in  = 14'(y_ff - q2p_ff);
      r2c_in = (r2_in >= 14'(HASH_SPAN)) ? 13'(r2_in - 14'(HASH_SPAN)) : 13'(r2_in);
      r3_in  = 14'(32'(src_ff) - q3b_ff);
      r3c_in = (32'(r3_in) >= 32'(BUCKETS)) ? 14'(32'(r3_in) - 32'(BUCKETS)) : r3_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-2:0], start};
      end
      x_ff      <= 32'((25'(in_pos) + 25'd1) * 33'(lang_model));
      m1_ff     <= 64'(x_ff) * 64'(PRIME_RCP);
      qp_ff     <= 32'(m1_ff[63:48] * 33'(HASH_PRIME));
      h1_ff     <= 32'(r1c_in) + 32'(lang_model) - 32'd1;
      y_ff      <= 32'(48'(ctx_pos) * 48'(h1_ff));
      m2_ff     <= 64'(y_ff) * 64'(SPAN_RCP);
      q2p_ff    <= 32'(m2_ff[63:44] * 33'(HASH_SPAN));
      src_ff    <= (ctx_pos == 16'd0) ? 13'(lang_model) : r2c_in;
      m3_ff     <= 36'(src_ff) * 36'(BKT_RCP);
      q3b_ff    <= 32'(m3_ff[35:26]) * 32'(BUCKETS);
      bucket_ff <= BW'(r3c_in);
   end

   assign done   = vld_ff[NSTG-1];
   assign bucket = bucket_ff;

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      done |-> (32'(bucket_ff) < 32'(BUCKETS)))
      else $error("bucket index out of range");
   a_span_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] |-> (src_ff < HASH_SPAN))
      else $error("span remainder not reduced");
   a_prime_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> ($past(r1c_in) < 18'(HASH_PRIME)))
      else $error("prime remainder not reduced");

endmodule

// ===== sv/path_hash_table_min_update_core.sv =====
// Top level of the path hash table with keep-minimum update.
// Add/find pass through the staged hash unit, a memory read, a modify/write step and an
// output load before rsp_tvalid rises; a no-op command goes straight to the output load.
// Only one transaction is handled at a time, held by the staged hash unit and the
// read-modify-write of one bucket row; clear sweeps all BUCKETS rows before it responds.
// Reset: synchronous, sweeps all BUCKETS rows to invalid (req_tready low during the sweep).
module path_hash_table_min_update_core #(
   parameter int BUCKETS = pht_pkg::BUCKETS_DEF,
   parameter int WAYS    = pht_pkg::WAYS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // xform_model[7:0], lang_model[15:8], in_pos[39:16], ctx_pos[55:40],
   // new_total[87:56], new_symbol[103:88]
   input  logic [103:0] req_tdata,
   // command[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // found[0], added[1], updated[2], table_full[3], stored_total[35:4],
   // stored_symbol[51:36], entry_count[66:52], zero fill [71:67]
   output logic [71:0]  rsp_tdata
);
   import pht_pkg::*;

   localparam int BW    = $clog2(BUCKETS);
   localparam int WIW   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOTS = BUCKETS * WAYS;
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int RES_W = 67;

   typedef enum logic [2:0] {
      S_IDLE, S_SWEEP, S_HASH, S_MODIFY, S_OUT
   } state_type;

   // Transaction fields, held for the whole operation
   state_type        st_ff, st_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [7:0]       xf_ff, xf_in;
   logic [7:0]       lang_ff, lang_in;
   logic [23:0]      pos_ff, pos_in;
   logic [15:0]      ctx_ff, ctx_in;
   logic [TOT_W-1:0] ntot_ff, ntot_in;
   logic [SYM_W-1:0] nsym_ff, nsym_in;
   logic             start_ff, start_in;
   logic [BW-1:0]    sw_ff, sw_in;
   logic             sw_rsp_ff, sw_rsp_in;
   logic [BW-1:0]    bkt_ff, bkt_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [71:0]      rsp_data_ff, rsp_data_in;

   logic             hash_done;
   logic [BW-1:0]    hash_bucket;

   slot_type [WAYS-1:0] slot_mem [BUCKETS];
   slot_type [WAYS-1:0] mem_rd_ff;
   slot_type [WAYS-1:0] mem_wd;
   logic                mem_we;
   logic [BW-1:0]       mem_wa;

   // Bucket search results for the modify cycle
   logic [KEY_W-1:0] key;
   logic             hit;
   logic [WIW-1:0]   hit_w;
   logic             free;
   logic [WIW-1:0]   free_w;
   logic             ins;
   logic             imp;
   slot_type [WAYS-1:0] new_row;
   logic             f_found, f_added, f_upd, f_full;
   logic [TOT_W-1:0] f_tot;
   logic [SYM_W-1:0] f_sym;

   pht_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .lang_model (lang_ff),
      .in_pos     (pos_ff),
      .ctx_pos    (ctx_ff),
      .done       (hash_done),
      .bucket     (hash_bucket)
   );

   // One row per bucket: read it when the hash finishes, write it back in modify
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= slot_mem[hash_bucket];
   end

   // Search the row: first matching valid way, lowest free way
   always_comb begin
      key     = {xf_ff, lang_ff, pos_ff, ctx_ff};
      hit     = 1'b0;
      hit_w   = '0;
      free    = 1'b0;
      free_w  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (mem_rd_ff[w].valid) begin
            if (!hit && mem_rd_ff[w].key == key) begin
               hit   = 1'b1;
               hit_w = WIW'(w);
            end
         end else if (!free) begin
            free   = 1'b1;
            free_w = WIW'(w);
         end
      end

      imp     = (cmd_ff == CMD_ADD) && hit && (ntot_ff < mem_rd_ff[hit_w].total);
      ins     = (cmd_ff == CMD_ADD) && !hit && free;
      new_row = mem_rd_ff;
      if (imp) begin
         new_row[hit_w].total  = ntot_ff;
         new_row[hit_w].symbol = nsym_ff;
      end
      if (ins) begin
         new_row[free_w].valid  = 1'b1;
         new_row[free_w].key    = key;
         new_row[free_w].total  = ntot_ff;
         new_row[free_w].symbol = nsym_ff;
      end

      f_found = hit;
      f_added = ins;
      f_upd   = ins || imp;
      f_full  = (cmd_ff == CMD_ADD) && !hit && !free;
      f_tot   = '0;
      f_sym   = '0;
      if (hit) begin
         f_tot = new_row[hit_w].total;
         f_sym = new_row[hit_w].symbol;
      end else if (ins) begin
         f_tot = ntot_ff;
         f_sym = nsym_ff;
      end
   end

   // Memory write port: clearing sweep or row write-back
   always_comb begin
      mem_we = 1'b0;
      mem_wa = bkt_ff;
      mem_wd = new_row;
      unique case (st_ff)
         S_SWEEP: begin
            mem_we = 1'b1;
            mem_wa = sw_ff;
            mem_wd = '0;
         end
         S_MODIFY: begin
            mem_we = ins || imp;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      st_in       = st_ff;
      cmd_in      = cmd_ff;
      xf_in       = xf_ff;
      lang_in     = lang_ff;
      pos_in      = pos_ff;
      ctx_in      = ctx_ff;
      ntot_in     = ntot_ff;
      nsym_in     = nsym_ff;
      start_in    = 1'b0;
      sw_in       = sw_ff;
      sw_rsp_in   = sw_rsp_ff;
      bkt_in      = bkt_ff;
      cnt_in      = cnt_ff;
      res_in      = res_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // capture the transaction and pick its path
               cmd_in  = req_tuser;
               xf_in   = req_tdata[7:0];
               lang_in = req_tdata[15:8];
               pos_in  = req_tdata[39:16];
               ctx_in  = req_tdata[55:40];
               ntot_in = req_tdata[87:56];
               nsym_in = req_tdata[103:88];
               case (req_tuser)
                  CMD_ADD, CMD_FIND: begin
                     start_in = 1'b1;
                     st_in    = S_HASH;
                  end
                  CMD_CLEAR: begin
                     cnt_in    = '0;
                     sw_in     = '0;
                     sw_rsp_in = 1'b1;
                     st_in     = S_SWEEP;
                  end
                  default: begin
                     // unused command: report only the entry count
                     res_in = {15'(cnt_ff), 52'd0};
                     st_in  = S_OUT;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            sw_in = BW'(sw_ff + 1'b1);
            if (32'(sw_ff) == 32'(BUCKETS - 1)) begin
               res_in = '0;
               st_in  = sw_rsp_ff ? S_OUT : S_IDLE;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               bkt_in = hash_bucket;
               st_in  = S_MODIFY;
            end
         end
         S_MODIFY: begin
            if (ins) begin
               cnt_in = CW'(cnt_ff + 1'b1);
            end
            res_in = {15'(ins ? CW'(cnt_ff + 1'b1) : cnt_ff), f_sym, f_tot,
                      f_full, f_upd, f_added, f_found};
            st_in  = S_OUT;
         end
         S_OUT: begin
            // load the output register once it is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {5'd0, res_ff};
               st_in       = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_SWEEP;
         sw_ff      <= '0;
         sw_rsp_ff  <= 1'b0;
         start_ff   <= 1'b0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         sw_ff      <= sw_in;
         sw_rsp_ff  <= sw_rsp_in;
         start_ff   <= start_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cmd_ff      <= cmd_in;
      xf_ff       <= xf_in;
      lang_ff     <= lang_in;
      pos_ff      <= pos_in;
      ctx_ff      <= ctx_in;
      ntot_ff     <= ntot_in;
      nsym_ff     <= nsym_in;
      bkt_ff      <= bkt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= SLOTS)
      else $error("entry count exceeds table size");
   a_hash_to_modify: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_HASH && hash_done) |=> (st_ff == S_MODIFY))
      else $error("hash completion not followed by modify");
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (st_ff == S_SWEEP || st_ff == S_MODIFY))
      else $error("memory written outside sweep or modify");
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_MODIFY && ins) |=> (cnt_ff == CW'($past(cnt_ff) + 1'b1)))
      else $error("insert did not advance the entry count");
   a_added_updated: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (!rsp_data_ff[1] || rsp_data_ff[2]))
      else $error("added without updated");

endmodule

// ===== sim/path_hash_table_min_update_core_tb.sv =====
// Testbench for the path hash table with keep-minimum update.
// Drives add/find/clear/no-op transactions over the request stream and checks every response
// against a behavioral table model; depends on pht_pkg and path_hash_table_min_update_core.
`timescale 1ns / 1ps

module path_hash_table_min_update_core_tb;
   import pht_pkg::*;

   localparam int NBUCKET = BUCKETS_DEF;
   localparam int NWAY    = WAYS_DEF;
   localparam int NSLOT   = NBUCKET * NWAY;
   localparam logic [1:0] CMD_NOP = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  xform;
      logic [7:0]  lang;
      logic [23:0] pos;
      logic [15:0] ctx;
      logic [31:0] total;
      logic [15:0] symbol;
   } path_req_type;

   typedef struct packed {
      logic [14:0] count;
      logic [15:0] symbol;
      logic [31:0] total;
      logic        full;
      logic        updated;
      logic        added;
      logic        found;
   } path_rsp_type;

   // directed row: request, whether the expected response was typed in, and that response
   typedef struct {
      path_req_type req;
      bit           typed;
      path_rsp_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;

   path_hash_table_min_update_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // shadow table
   bit          tbl_valid [NSLOT];
   logic [55:0] tbl_key   [NSLOT];
   logic [31:0] tbl_total [NSLOT];
   logic [15:0] tbl_symbol[NSLOT];
   int unsigned tbl_count;

   path_rsp_type rsp_pending[$];
   int          errors;
   int          rsp_seen;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          n_add, n_hit, n_full, n_clear;

   // recent keys, reused so adds and finds actually hit
   path_req_type key_pool[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TIMEOUT at %0t", $time);
      $display("path_hash_table_min_update_core verification failed");
      $finish;
   end

   function automatic int unsigned bucket_index(logic [7:0] lang, logic [23:0] pos,
                                                logic [15:0] ctx);
      logic [31:0] h1;
      logic [31:0] h2;
      if (ctx == 16'd0) return 32'(lang) % NBUCKET;
      h1 = ((32'(pos) + 32'd1) * 32'(lang)) % 32'd103669;
      h1 = h1 + (32'(lang) - 32'd1);
      h2 = (32'(ctx) * h1) % 32'd5003;
      return h2 % NBUCKET;
   endfunction

   // apply one request to the shadow table and return the response it must produce
   function automatic path_rsp_type table_apply(path_req_type r);
      path_rsp_type o;
      logic [55:0] key;
      int unsigned base;
      int          hit, free_way;
      o = '0;
      key = {r.xform, r.lang, r.pos, r.ctx};
      hit = -1;
      free_way = -1;
      if (r.cmd == CMD_CLEAR) begin
         foreach (tbl_valid[i]) tbl_valid[i] = 0;
         tbl_count = 0;
      end else if (r.cmd == CMD_ADD || r.cmd == CMD_FIND) begin
         base = bucket_index(r.lang, r.pos, r.ctx) * NWAY;
         for (int w = 0; w < NWAY; w++) begin
            if (tbl_valid[base+w]) begin
               if (hit < 0 && tbl_key[base+w] == key) hit = base + w;
            end else if (free_way < 0) begin
               free_way = base + w;
            end
         end
         if (hit >= 0) begin
            o.found = 1'b1;
            if (r.cmd == CMD_ADD && r.total < tbl_total[hit]) begin
               tbl_total[hit]  = r.total;
               tbl_symbol[hit] = r.symbol;
               o.updated = 1'b1;
            end
            o.total  = tbl_total[hit];
            o.symbol = tbl_symbol[hit];
         end else if (r.cmd == CMD_ADD) begin
            if (free_way >= 0) begin
               tbl_valid[free_way]  = 1;
               tbl_key[free_way]    = key;
               tbl_total[free_way]  = r.total;
               tbl_symbol[free_way] = r.symbol;
               tbl_count++;
               o.added   = 1'b1;
               o.updated = 1'b1;
               o.total   = r.total;
               o.symbol  = r.symbol;
            end else begin
               o.full = 1'b1;
            end
         end
      end
      o.count = 15'(tbl_count);
      return o;
   endfunction

   // present one transaction, hold until accepted, and queue its expected response;
   // valid stays high after acceptance so back-to-back transactions drive it only once
   task automatic send_path(path_req_type r, bit typed, path_rsp_type typed_rsp);
      path_rsp_type model;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.symbol, r.total, r.ctx, r.pos, r.lang, r.xform};
      req_tuser  <= r.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model = table_apply(r);
      // typed rows must agree with the model too; flag a bad table entry
      if (typed && model != typed_rsp) begin
         $display("%0t: directed row disagrees with model exp=%h model=%h",
                  $time, typed_rsp, model);
         errors++;
      end
      rsp_pending.push_back(typed ? typed_rsp : model);
      if (r.cmd == CMD_ADD) n_add++;
      if (r.cmd == CMD_CLEAR) n_clear++;
      if (model.found) n_hit++;
      if (model.full) n_full++;
   endtask

   // response side: random stall, compare each accepted transaction with the oldest entry
   initial begin
      path_rsp_type got, want;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = path_rsp_type'(rsp_tdata[66:0]);
            rsp_seen++;
            if (rsp_pending.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = rsp_pending.pop_front();
               if (got.found !== want.found)
                  $display("%0t: found exp=%0d got=%0d", $time, want.found, got.found);
               if (got.added !== want.added)
                  $display("%0t: added exp=%0d got=%0d", $time, want.added, got.added);
               if (got.updated !== want.updated)
                  $display("%0t: updated exp=%0d got=%0d", $time, want.updated, got.updated);
               if (got.full !== want.full)
                  $display("%0t: table_full exp=%0d got=%0d", $time, want.full, got.full);
               if (got.total !== want.total)
                  $display("%0t: stored_total exp=%h got=%h", $time, want.total, got.total);
               if (got.symbol !== want.symbol)
                  $display("%0t: stored_symbol exp=%h got=%h", $time, want.symbol, got.symbol);
               if (got.count !== want.count)
                  $display("%0t: entry_count exp=%0d got=%0d", $time, want.count, got.count);
               if (got !== want) errors++;
               if (rsp_tdata[71:67] !== 5'd0) begin
                  $display("%0t: fill bits exp=0 got=%h", $time, rsp_tdata[71:67]);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic path_req_type mk(logic [1:0] c, logic [7:0] x, logic [7:0] l,
                                       logic [23:0] p, logic [15:0] cx, logic [31:0] t,
                                       logic [15:0] s);
      mk = '{cmd: c, xform: x, lang: l, pos: p, ctx: cx, total: t, symbol: s};
   endfunction

   function automatic path_rsp_type rs(bit f, bit a, bit u, bit fl, logic [31:0] t,
                                       logic [15:0] s, int c);
      rs = '{count: 15'(c), symbol: s, total: t, full: fl, updated: u, added: a, found: f};
   endfunction

   // random request: mostly reuse known keys, some fresh keys, rare clears and no-ops
   function automatic path_req_type random_path();
      path_req_type r;
      int           pick;
      r = path_req_type'({$urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(99);
      if (key_pool.size() > 0 && pick < 55) begin
         path_req_type k;
         k = key_pool[$urandom_range(key_pool.size() - 1)];
         r.xform = k.xform; r.lang = k.lang; r.pos = k.pos; r.ctx = k.ctx;
      end else if (pick < 75) begin
         // crowd a few buckets with the simple hash to hit full buckets
         r.ctx  = '0;
         r.lang = 8'($urandom_range(3));
      end
      pick = $urandom_range(99);
      r.cmd = (pick < 60) ? CMD_ADD : (pick < 97) ? CMD_FIND : (pick < 98) ? CMD_CLEAR : CMD_NOP;
      if ($urandom_range(3) == 0) r.total = 32'($urandom_range(255));
      return r;
   endfunction

   stim_row_type rows[$];

   initial begin
      int           guard;
      path_req_type r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_NOP;
      errors = 0; rsp_seen = 0; tbl_count = 0;
      n_add = 0; n_hit = 0; n_full = 0; n_clear = 0;
      send_idle_pct = 0; recv_idle_pct = 0;
      foreach (tbl_valid[i]) tbl_valid[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table: empty finds, extremes, keep-minimum, full bucket, no-op, clear
      rows.push_back('{mk(CMD_FIND, 8'h00, 8'h00, 24'h0, 16'h0, 0, 0), 1,
                       rs(0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_ADD, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF),
                       1, rs(0, 1, 1, 0, 32'hFFFFFFFF, 16'hFFFF, 1)});
      rows.push_back('{mk(CMD_ADD, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'h1),
                       1, rs(1, 0, 0, 0, 32'hFFFFFFFF, 16'hFFFF, 1)});
      rows.push_back('{mk(CMD_ADD, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 32'h0, 16'h0),
                       1, rs(1, 0, 1, 0, 0, 0, 1)});
      rows.push_back('{mk(CMD_FIND, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 32'h5, 16'h5),
                       1, rs(1, 0, 0, 0, 0, 0, 1)});
      // five keys in bucket of lang 0 via simple hash: fifth finds it full
      for (int i = 0; i < 5; i++)
         rows.push_back('{mk(CMD_ADD, 8'(i), 8'h00, 24'(i), 16'h0, 32'(100 + i), 16'(i)),
                          i == 4, rs(0, 0, 0, 1, 0, 0, 5)});
      rows.push_back('{mk(CMD_FIND, 8'h04, 8'h00, 24'h4, 16'h0, 0, 0), 1,
                       rs(0, 0, 0, 0, 0, 0, 5)});
      rows.push_back('{mk(CMD_FIND, 8'h02, 8'h00, 24'h2, 16'h0, 0, 0), 0, '0});
      rows.push_back('{mk(CMD_ADD, 8'h01, 8'h00, 24'h1, 16'h0, 32'd101, 16'h7), 0, '0});
      rows.push_back('{mk(CMD_NOP, 8'hAA, 8'h55, 24'hA5A5A5, 16'h5A5A, 32'h1234, 16'h1), 1,
                       rs(0, 0, 0, 0, 0, 0, 5)});
      rows.push_back('{mk(CMD_ADD, 8'h80, 8'h00, 24'h800000, 16'h8000, 32'h80000000,
                          16'h8000), 0, '0});
      rows.push_back('{mk(CMD_ADD, 8'h01, 8'h01, 24'h0, 16'h1, 32'h10, 16'h10), 0, '0});
      rows.push_back('{mk(CMD_CLEAR, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF,
                          16'hFFFF), 1, rs(0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_FIND, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 0, 0), 1,
                       rs(0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_ADD, 8'h00, 8'h00, 24'h0, 16'h0, 32'h0, 16'h0), 1,
                       rs(0, 1, 1, 0, 0, 0, 1)});
      rows.push_back('{mk(CMD_ADD, 8'h00, 8'h00, 24'h0, 16'h0, 32'h0, 16'hFFFF), 1,
                       rs(1, 0, 0, 0, 0, 0, 1)});
      foreach (rows[i]) send_path(rows[i].req, rows[i].typed, rows[i].rsp);
      req_tvalid <= 1'b0;

      // hold off until the directed responses have drained
      guard = 0;
      while (rsp_pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end

      // random part in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 66 : 0;
         recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 26 : 0;
         for (int n = 0; n < 267; n++) begin
            r = random_path();
            if (r.cmd == CMD_ADD) begin
               key_pool.push_back(r);
               if (key_pool.size() > 64) void'(key_pool.pop_front());
            end
            send_path(r, 0, '0);
         end
      end
      req_tvalid <= 1'b0;

      guard = 0;
      while (rsp_pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);

      $display("Covered %0d responses: %0d adds, %0d hits, %0d full-bucket misses, %0d clears",
               rsp_seen, n_add, n_hit, n_full, n_clear);
      if (errors == 0 && rsp_pending.size() == 0) begin
         $display("path_hash_table_min_update_core verification clean");
      end else begin
         $display("%0d errors, %0d responses missing", errors, rsp_pending.size());
         $display("path_hash_table_min_update_core verification failed");
      end
      $finish;
   end

endmodule
